// ----- rtl/core/oklch_to_srgb_converter_assert.svh -----
// Assertion macros used by the checker module of the OKLCh to sRGB converter.
// Each macro expects clk_i to be visible where it is used; OKLCH_ASSERT also rst_ni.
`ifndef OKLCH_TO_SRGB_CONVERTER_ASSERT_SVH
`define OKLCH_TO_SRGB_CONVERTER_ASSERT_SVH

// Checked on every rising clock edge while reset is released.
`define OKLCH_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("oklch_to_srgb_converter: assertion failed");

// Checked on every rising clock edge, reset included.
`define OKLCH_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("oklch_to_srgb_converter: assertion failed");

`endif

// ----- rtl/core/oklch2rgb_pkg.sv -----
// Shared types, constants and table generators of the OKLCh to sRGB converter.
// Used by oklch2rgb_gamma and oklch_to_srgb_converter; depends on nothing else.
package oklch2rgb_pkg;

  localparam int unsigned OutputBitsDef = 12;
  localparam int unsigned GammaBitsDef  = 10;
  localparam int unsigned SineBitsDef   = 10;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned HueW     = 15;
  localparam int unsigned ChanW    = 16;
  localparam int unsigned HueTurn  = 23040;
  localparam int unsigned LinKnee  = 3283;

  // Reciprocals for the two constant divisions (by 45 and by 100).
  localparam int unsigned HueRecipM = 372827;
  localparam int unsigned HueRecipK = 24;
  localparam int unsigned LinRecipM = 10737418;
  localparam int unsigned LinRecipK = 30;

  localparam longint unsigned TwoPiQ30 = 64'd6746518852;

  // Signed Q2.20 working value and Q1.20 table entry.
  typedef logic signed [22:0] q_t;
  typedef logic signed [21:0] tab_t;
  typedef logic signed [23:0] coef_t;

  localparam q_t QMax = 23'sh3FFFFF;
  localparam q_t QMin = -23'sh400000;

  localparam coef_t CoefLab [3][2] = '{
    '{ 24'sd415590,   24'sd226287},
    '{-24'sd110689,  -24'sd66956},
    '{-24'sd93831,  -24'sd1354221}
  };

  localparam coef_t CoefRgb [3][3] = '{
    '{ 24'sd4274773, -24'sd3468387,  24'sd242190},
    '{-24'sd1330054,  24'sd2736529, -24'sd357899},
    '{-24'sd4400,    -24'sd737588,   24'sd1790564}
  };

  function automatic q_t sat_q(input logic signed [31:0] v);
    if (v > 32'sd4194303) begin
      return QMax;
    end else if (v < -32'sd4194304) begin
      return QMin;
    end
    return q_t'(v);
  endfunction

  // Q2.20 product, rounded half up and saturated.
  function automatic q_t qmul(input q_t x, input q_t y);
    logic signed [45:0] p;
    logic signed [45:0] r;
    p = x * y;
    r = (p + 46'sd524288) >>> 20;
    return sat_q(32'(r));
  endfunction

  // Taylor series of sin(2*pi*r/2^bits) in Q30, returned in Q20.
  function automatic longint quarter_sin(input longint unsigned r, input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int              n;
    x    = (r * TwoPiQ30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      unique case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        default: term = term / 210;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      return 0;
    end
    sum = (sum + 512) >>> 10;
    return (sum > 64'sd1048576) ? 64'sd1048576 : sum;
  endfunction

  function automatic tab_t sine_entry(input int unsigned k, input int unsigned bits);
    longint unsigned quarter;
    longint unsigned q;
    longint unsigned r;
    longint          v;
    quarter = 64'd1 << (bits - 2);
    q       = longint'(k) >> (bits - 2);
    r       = longint'(k) & (quarter - 1);
    v       = q[0] ? quarter_sin(quarter - r, bits) : quarter_sin(r, bits);
    return q[1] ? tab_t'(-v) : tab_t'(v);
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (mid * mid <= v) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic longint unsigned icbrt64(input longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd2097152;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (mid * mid * mid <= v) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  // Encoded curve 1.055*x^(5/12) - 0.055 at x = k/2^bits, Q20.
  function automatic tab_t gamma_entry(input int unsigned k, input int unsigned bits);
    longint unsigned s2;
    longint unsigned q4;
    longint unsigned c3;
    longint unsigned q6;
    longint unsigned y;
    s2 = isqrt64(longint'(k) << (62 - bits));
    q4 = isqrt64(s2 << 31);
    c3 = icbrt64(longint'(k) << (63 - bits));
    q6 = isqrt64(c3 << 41);
    y  = (q4 * q6) >> 32;
    return tab_t'(longint'((y * 1055 + 512000) / 1024000) - 57672);
  endfunction

endpackage

// ----- rtl/core/oklch2rgb_gamma.sv -----
// sRGB transfer curve of one linear channel: linear knee or interpolated power table.
// Three register stages plus output scaling; depends on oklch2rgb_pkg.
module oklch2rgb_gamma import oklch2rgb_pkg::*; #(
  parameter int unsigned OUTPUT_BITS      = OutputBitsDef,
  parameter int unsigned GAMMA_TABLE_BITS = GammaBitsDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [20:0]            lin_i,
  output logic [OUTPUT_BITS-1:0] code_o
);

  localparam int unsigned GamN  = 1 << GAMMA_TABLE_BITS;
  localparam int unsigned IdxW  = GAMMA_TABLE_BITS + 1;
  localparam int unsigned FracW = 20 - GAMMA_TABLE_BITS;
  localparam int unsigned CodeW = 24 + OUTPUT_BITS;

  tab_t gam_tab [GamN+1];

  for (genvar k = 0; k <= GamN; k++) begin : g_tab
    localparam tab_t Entry = gamma_entry(k, GAMMA_TABLE_BITS);
    assign gam_tab[k] = Entry;
  end

  // First stage: table reads and the linear-branch numerator.
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   idx_n;
  logic              at_top;
  tab_t              g0;
  tab_t              g1;
  logic              knee_d;
  q_t                g0_d;
  q_t                diff_d;
  logic [19:0]       f_d;
  logic [22:0]       n_d;

  always_comb begin
    idx    = lin_i[20 -: IdxW];
    at_top = idx[IdxW-1];
    idx_n  = at_top ? idx : idx + IdxW'(1);
    g0     = gam_tab[idx];
    g1     = gam_tab[idx_n];
    knee_d = (lin_i < 21'(LinKnee));
    g0_d   = q_t'(g0);
    diff_d = at_top ? '0 : q_t'(g1) - q_t'(g0);
    f_d    = {lin_i[FracW-1:0], {GAMMA_TABLE_BITS{1'b0}}};
    n_d    = 23'(lin_i[11:0]) * 23'd1292 + 23'd50;
  end

  logic              knee1_q;
  q_t                g0_1_q;
  q_t                diff1_q;
  logic [19:0]       f1_q;
  logic [22:0]       n1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee1_q <= knee_d;
      g0_1_q  <= g0_d;
      diff1_q <= diff_d;
      f1_q    <= f_d;
      n1_q    <= n_d;
    end
  end

  // Second stage: interpolation product and reciprocal estimate of n / 100.
  logic signed [43:0] prod_d;
  logic [46:0]        lp;
  logic [15:0]        qe_d;

  always_comb begin
    prod_d = diff1_q * $signed({1'b0, f1_q});
    lp     = 47'(n1_q) * 47'(LinRecipM);
    qe_d   = 16'(lp >> LinRecipK);
  end

  logic               knee2_q;
  q_t                 g0_2_q;
  logic signed [43:0] prod2_q;
  logic [15:0]        qe2_q;
  logic [22:0]        n2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee2_q <= knee1_q;
      g0_2_q  <= g0_1_q;
      prod2_q <= prod_d;
      qe2_q   <= qe_d;
      n2_q    <= n1_q;
    end
  end

  // Third stage: finish either branch.
  logic [22:0]        rem;
  logic [15:0]        lq;
  logic signed [43:0] rr;
  q_t                 e_d;

  always_comb begin
    rem = n2_q - 23'(qe2_q) * 23'd100;
    lq  = (rem >= 23'd100) ? qe2_q + 16'd1 : qe2_q;
    rr  = (prod2_q + 44'sd524288) >>> 20;
    e_d = knee2_q ? q_t'({7'b0, lq}) : g0_2_q + q_t'(rr);
  end

  q_t e3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e3_q <= e_d;
    end
  end

  // Scale to the output code, rounded half up, then saturated.
  logic signed [CodeW-1:0] cw;
  logic signed [CodeW-1:0] cr;

  always_comb begin
    cw = (CodeW'(e3_q) <<< OUTPUT_BITS) - CodeW'(e3_q);
    cr = (cw + CodeW'(524288)) >>> 20;
    if (cr < 0) begin
      code_o = '0;
    end else if (cr > CodeW'((1 << OUTPUT_BITS) - 1)) begin
      code_o = '1;
    end else begin
      code_o = cr[OUTPUT_BITS-1:0];
    end
  end

endmodule

// ----- rtl/core/oklch_to_srgb_converter.sv -----
// OKLCh to gamma-encoded sRGB converter, top level with stream ports.
// Depends on oklch2rgb_pkg and oklch2rgb_gamma.
//
// Usage: one OKLCh colour enters per word on the slave stream and one sRGB
// colour leaves per word on the master stream, in order.
// Input word: hue in 1/64 degree, chroma and lightness as Q0.16 fractions.
// Output word: red, green and blue codes of OUTPUT_BITS each; tuser carries
// the clip flag, set when any linear channel fell outside 0..1.
// Throughput: one word per clock while the receiver keeps up. The datapath
// is a 14-stage pipeline (hue index, sine lookup, Lab to LMS, two cubing
// multiplies, LMS to RGB, three gamma stages); a word passes all of them and
// the output register before it shows on the master side, later if the receiver stalls.
// A two-entry output buffer lets the pipeline deliver one more word after a
// stall begins; s_axis_tready_o drops only while both entries are full and
// returns in the cycle after the receiver takes a word. Nothing is lost
// or repeated. Reset clears all valid flags and holds s_axis_tready_o low;
// words are accepted from the first clock edge after reset is released.
module oklch_to_srgb_converter import oklch2rgb_pkg::*; #(
  parameter int unsigned OUTPUT_BITS      = OutputBitsDef,
  parameter int unsigned GAMMA_TABLE_BITS = GammaBitsDef,
  parameter int unsigned SINE_TABLE_BITS  = SineBitsDef,
  localparam int unsigned OutDataW = ((3 * OUTPUT_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // hue [14:0], chroma [30:15], lightness [46:31], zero [47]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // red, green, blue from bit 0 up, OUTPUT_BITS each, zero padded
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // clipped [0]
  output logic [0:0]          m_axis_tuser_o
);

  localparam int unsigned SinN     = 1 << SINE_TABLE_BITS;
  localparam int unsigned HueNumW  = SINE_TABLE_BITS + 16;
  localparam int unsigned TW       = SINE_TABLE_BITS + 6;
  localparam int unsigned QeW      = TW - 5;
  localparam int unsigned PipeW    = 14;
  localparam int unsigned ResW     = 3 * OUTPUT_BITS + 1;

  logic ena;
  logic [PipeW-1:0] vld_q;

  assign s_axis_tready_o = ena && rst_ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ena) begin
      vld_q <= {vld_q[PipeW-2:0], s_axis_tvalid_i};
    end
  end

  tab_t sin_tab [SinN];

  for (genvar k = 0; k < SinN; k++) begin : g_sin
    localparam tab_t SinV = sine_entry(k, SINE_TABLE_BITS);
    assign sin_tab[k] = SinV;
  end

  // Stage 1: hue wrapped to one turn, scaled toward a table index.
  logic [HueW-1:0]    hue;
  logic [HueW-1:0]    hmod;
  logic [HueNumW-1:0] num;
  logic [TW-1:0]      t1_q;
  logic [ChanW-1:0]   c1_q, l1_q;

  always_comb begin
    hue  = s_axis_tdata_i[HueW-1:0];
    hmod = (hue >= HueW'(HueTurn)) ? hue - HueW'(HueTurn) : hue;
    num  = (HueNumW'(hmod) << (SINE_TABLE_BITS + 1)) + HueNumW'(HueTurn);
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      t1_q <= num[HueNumW-1:10];
      c1_q <= s_axis_tdata_i[30:15];
      l1_q <= s_axis_tdata_i[46:31];
    end
  end

  // Stage 2: estimate of t / 45 by reciprocal.
  logic [TW+18:0]   hp;
  logic [QeW-1:0]   qe2_q;
  logic [TW-1:0]    t2_q;
  logic [ChanW-1:0] c2_q, l2_q;

  assign hp = (TW+19)'(t1_q) * (TW+19)'(HueRecipM);

  always_ff @(posedge clk_i) begin
    if (ena) begin
      qe2_q <= hp[TW+18:HueRecipK];
      t2_q  <= t1_q;
      c2_q  <= c1_q;
      l2_q  <= l1_q;
    end
  end

  // Stage 3: the estimate may be one low; correct it.
  logic [TW-1:0]              hrem;
  logic [QeW-1:0]             hq;
  logic [SINE_TABLE_BITS-1:0] idx3_q;
  logic [ChanW-1:0]           c3_q, l3_q;

  always_comb begin
    hrem = t2_q - TW'(qe2_q) * TW'(45);
    hq   = (hrem >= TW'(45)) ? qe2_q + QeW'(1) : qe2_q;
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      idx3_q <= hq[SINE_TABLE_BITS-1:0];
      c3_q   <= c2_q;
      l3_q   <= l2_q;
    end
  end

  // Stage 4: cosine is the sine a quarter turn ahead.
  tab_t             cos4_q, sin4_q;
  logic [ChanW-1:0] c4_q, l4_q;

  always_ff @(posedge clk_i) begin
    if (ena) begin
      cos4_q <= sin_tab[idx3_q + SINE_TABLE_BITS'(SinN / 4)];
      sin4_q <= sin_tab[idx3_q];
      c4_q   <= c3_q;
      l4_q   <= l3_q;
    end
  end

  // Stage 5: a and b in Q20.
  logic signed [38:0] pa, pb;
  q_t                 a5_q, b5_q, lum5_q;

  always_comb begin
    pa = $signed({1'b0, c4_q}) * cos4_q;
    pb = $signed({1'b0, c4_q}) * sin4_q;
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      a5_q   <= q_t'((pa + 39'sd32768) >>> 16);
      b5_q   <= q_t'((pb + 39'sd32768) >>> 16);
      lum5_q <= q_t'({3'b000, l4_q, 4'b0000});
    end
  end

  // Stage 6: Lab to LMS products.
  logic signed [46:0] pm6_q [3][2];
  q_t                 lum6_q;

  always_ff @(posedge clk_i) begin
    if (ena) begin
      for (int i = 0; i < 3; i++) begin
        pm6_q[i][0] <= a5_q * CoefLab[i][0];
        pm6_q[i][1] <= b5_q * CoefLab[i][1];
      end
      lum6_q <= lum5_q;
    end
  end

  // Stage 7: sum, round, add lightness, saturate.
  logic signed [47:0] lsum [3];
  logic signed [47:0] lrnd [3];
  q_t                 v7_d [3];
  q_t                 v7_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsum[i] = 48'(pm6_q[i][0]) + 48'(pm6_q[i][1]);
      lrnd[i] = (lsum[i] + 48'sd524288) >>> 20;
      v7_d[i] = sat_q(32'(lrnd[i]) + 32'(lum6_q));
    end
  end

  // Stages 8 and 9: cube each LMS channel.
  q_t vv8_q [3];
  q_t v8_q  [3];
  q_t cube9_q [3];

  always_ff @(posedge clk_i) begin
    if (ena) begin
      for (int i = 0; i < 3; i++) begin
        v7_q[i]    <= v7_d[i];
        vv8_q[i]   <= qmul(v7_q[i], v7_q[i]);
        v8_q[i]    <= v7_q[i];
        cube9_q[i] <= qmul(vv8_q[i], v8_q[i]);
      end
    end
  end

  // Stage 10: LMS to linear RGB products.
  logic signed [46:0] pr10_q [3][3];

  always_ff @(posedge clk_i) begin
    if (ena) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr10_q[i][j] <= cube9_q[j] * CoefRgb[i][j];
        end
      end
    end
  end

  // Stage 11: sum, round, clamp to 0..1 and flag clipping.
  logic signed [48:0] acc  [3];
  logic signed [48:0] arnd [3];
  logic [20:0]        lin_d [3];
  logic [2:0]         clip_ch;
  logic [20:0]        lin11_q [3];
  logic               clip11_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = 49'(pr10_q[i][0]) + 49'(pr10_q[i][1]) + 49'(pr10_q[i][2]);
      arnd[i] = (acc[i] + 49'sd524288) >>> 20;
      if (arnd[i] < 0) begin
        lin_d[i]   = '0;
        clip_ch[i] = 1'b1;
      end else if (arnd[i] > 49'sd1048576) begin
        lin_d[i]   = 21'd1048576;
        clip_ch[i] = 1'b1;
      end else begin
        lin_d[i]   = arnd[i][20:0];
        clip_ch[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      for (int i = 0; i < 3; i++) begin
        lin11_q[i] <= lin_d[i];
      end
      clip11_q <= |clip_ch;
    end
  end

  // Stages 12 to 14: transfer curve per channel, clip flag delayed alongside.
  logic [OUTPUT_BITS-1:0] code [3];
  logic [2:0]             clip_dly_q;

  for (genvar i = 0; i < 3; i++) begin : g_gamma
    oklch2rgb_gamma #(
      .OUTPUT_BITS      (OUTPUT_BITS),
      .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_gamma (
      .clk_i  (clk_i),
      .en_i   (ena),
      .lin_i  (lin11_q[i]),
      .code_o (code[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      clip_dly_q <= {clip_dly_q[1:0], clip11_q};
    end
  end

  // Output register with one skid entry.
  logic [ResW-1:0] pipe_res;
  logic            push;
  logic            out_valid_q, out_valid_d;
  logic            sk_valid_q, sk_valid_d;
  logic [ResW-1:0] out_res_q, out_res_d;
  logic [ResW-1:0] sk_res_q, sk_res_d;

  assign pipe_res = {clip_dly_q[2], code[2], code[1], code[0]};
  assign ena      = !sk_valid_q;
  assign push     = vld_q[PipeW-1] && ena;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    sk_valid_d  = sk_valid_q;
    sk_res_d    = sk_res_q;
    if (!out_valid_q || m_axis_tready_i) begin
      if (sk_valid_q) begin
        out_valid_d = 1'b1;
        out_res_d   = sk_res_q;
        sk_valid_d  = 1'b0;
      end else begin
        out_valid_d = push;
        out_res_d   = pipe_res;
      end
    end else if (push) begin
      sk_valid_d = 1'b1;
      sk_res_d   = pipe_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    sk_res_q  <= sk_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_res_q[ResW-2:0]);
  assign m_axis_tuser_o  = out_res_q[ResW-1];

endmodule

// ----- rtl/core/oklch2rgb_checker.sv -----
// Port-level checks of the OKLCh to sRGB converter, attached by bind.
// Depends on oklch_to_srgb_converter_assert.svh and the top level's ports.
`include "oklch_to_srgb_converter_assert.svh"

module oklch2rgb_checker #(
  parameter int unsigned OUT_W = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic [0:0]       m_axis_tuser_o
);

  // A stalled output word holds still.
  `OKLCH_ASSERT(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))

  // When the input side stalls, an output word is waiting.
  `OKLCH_ASSERT(a_full_has_word, (!s_axis_tready_o) |-> m_axis_tvalid_o)

  // A full buffer frees its skid entry when the receiver takes a word, so s_axis_tready_o returns.
  `OKLCH_ASSERT(a_ready_returns, (!s_axis_tready_o && m_axis_tready_i) |=> s_axis_tready_o)

  // No word appears straight out of reset.
  `OKLCH_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |=> !m_axis_tvalid_o)

endmodule

bind oklch_to_srgb_converter oklch2rgb_checker #(.OUT_W(OutDataW)) u_checker (.*);

// ----- tb/oklch_srgb_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the OKLCh to sRGB converter: predicts each colour from the input words.
// Depends only on the stream ports of the converter; it builds its own tables.
module oklch_srgb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [47:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,
  input  logic [0:0]  m_axis_tuser_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int SineN = 1024;
  localparam int GamN  = 1024;
  localparam longint QOne = 64'sd1048576;
  localparam longint QHi  = 64'sd4194303;
  localparam longint QLo  = -64'sd4194304;
  localparam longint Knee = 3283;
  localparam longint CodeTop = 4095;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
    logic        clipped;
  } srgb_t;

  longint sin_lut [SineN];
  longint gam_lut [GamN + 1];
  longint lab_m [3][2];
  longint rgb_m [3][3];
  srgb_t  colour_q [$];

  function automatic longint rshift_round(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_q(input longint v);
    return v > QHi ? QHi : (v < QLo ? QLo : v);
  endfunction

  function automatic longint fix_mul(input longint x, input longint y);
    return clamp_q(rshift_round(x * y, 20));
  endfunction

  // Taylor series in Q30 for a quarter turn, result in Q20.
  function automatic longint quarter_wave(input longint unsigned r);
    longint unsigned x, x2, term;
    longint sum;
    x = (r * 64'd6746518852) >> 10;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) return 0;
    sum = (sum + 512) >>> 10;
    return sum > QOne ? QOne : sum;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint unsigned int_cbrt(input longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd2097152;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint curve_point(input longint unsigned k);
    longint unsigned s2, q4, c3, q6, y;
    s2 = int_sqrt(k << 52);
    q4 = int_sqrt(s2 << 31);
    c3 = int_cbrt(k << 53);
    q6 = int_sqrt(c3 << 41);
    y = (q4 * q6) >> 32;
    return longint'((y * 1055 + 512000) / 1024000) - 57672;
  endfunction

  function automatic logic [11:0] encode_channel(input longint x);
    longint e, code, f;
    longint unsigned p, i;
    if (x < Knee) begin
      e = (x * 1292 + 50) / 100;
    end else begin
      p = longint'(x) << 10;
      i = p >> 20;
      f = longint'(p & 64'hFFFFF);
      if (i >= GamN) e = gam_lut[GamN];
      else e = gam_lut[i] + rshift_round((gam_lut[i + 1] - gam_lut[i]) * f, 20);
    end
    code = rshift_round(e * CodeTop, 20);
    if (code < 0) code = 0;
    if (code > CodeTop) code = CodeTop;
    return code[11:0];
  endfunction

  function automatic srgb_t predict_colour(input logic [47:0] w);
    longint h, c, lum, a, b, v, acc;
    longint unsigned idx;
    longint lms [3];
    longint lin [3];
    srgb_t res;
    h = longint'(w[14:0]) % 23040;
    c = longint'(w[30:15]);
    lum = longint'(w[46:31]) << 4;
    res.clipped = 1'b0;
    idx = ((longint'(h) * 2048 + 23040) / 46080) & (SineN - 1);
    a = rshift_round(c * sin_lut[(idx + SineN / 4) & (SineN - 1)], 16);
    b = rshift_round(c * sin_lut[idx], 16);
    for (int i = 0; i < 3; i++) begin
      v = clamp_q(lum + rshift_round(a * lab_m[i][0] + b * lab_m[i][1], 20));
      lms[i] = fix_mul(fix_mul(v, v), v);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += lms[j] * rgb_m[i][j];
      lin[i] = clamp_q(rshift_round(acc, 20));
      if (lin[i] < 0) begin
        lin[i] = 0;
        res.clipped = 1'b1;
      end else if (lin[i] > QOne) begin
        lin[i] = QOne;
        res.clipped = 1'b1;
      end
    end
    res.red = encode_channel(lin[0]);
    res.green = encode_channel(lin[1]);
    res.blue = encode_channel(lin[2]);
    return res;
  endfunction

  initial begin
    longint v;
    lab_m = '{'{415590, 226287}, '{-110689, -66956}, '{-93831, -1354221}};
    rgb_m = '{'{4274773, -3468387, 242190}, '{-1330054, 2736529, -357899},
              '{-4400, -737588, 1790564}};
    for (int k = 0; k < SineN; k++) begin
      v = ((k / 256) % 2 == 1) ? quarter_wave(256 - k % 256) : quarter_wave(k % 256);
      sin_lut[k] = (k / 512 == 1) ? -v : v;
    end
    for (int k = 0; k <= GamN; k++) gam_lut[k] = curve_point(k);
    errors_o = 0;
  end

  assign pending_o = colour_q.size();

  always @(posedge clk_i) begin
    srgb_t want, got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) colour_q.push_back(predict_colour(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[11:0], m_axis_tdata_i[23:12], m_axis_tdata_i[35:24],
               m_axis_tuser_i[0]};
        if (colour_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected output word %h", got);
        end else begin
          want = colour_q.pop_front();
          if (got !== want || m_axis_tdata_i[39:36] !== 4'h0) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: r/g/b/clip expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       want.red, want.green, want.blue, want.clipped,
                       got.red, got.green, got.blue, got.clipped);
          end
        end
      end
    end
  end

endmodule

// ----- tb/oklch_to_srgb_converter_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the OKLCh to sRGB converter: clock, reset, stimulus and verdict.
// Depends on oklch_to_srgb_converter and oklch_srgb_checker.
module oklch_to_srgb_converter_tb;

  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // hue [14:0], chroma [30:15], lightness [46:31], zero [47]
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // red [11:0], green [23:12], blue [35:24], zero [39:36]
  logic [39:0] m_axis_tdata_o;
  // clipped [0]
  logic [0:0]  m_axis_tuser_o;

  int errors, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int cycles = 0;

  oklch_to_srgb_converter dut (.*);

  oklch_srgb_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_colour(input logic [14:0] hue, input logic [15:0] chroma,
                             input logic [15:0] light);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, light, chroma, hue};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random;
    logic [14:0] hue;
    logic [15:0] chroma;
    hue = ($urandom_range(3) == 0) ? 15'($urandom_range(32767)) : 15'($urandom_range(23039));
    // Mostly modest chroma, which stays near the gamut; the rest is anything.
    chroma = ($urandom_range(9) < 7) ? 16'($urandom_range(16'h2C00)) : 16'($urandom);
    send_colour(hue, chroma, 16'($urandom));
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    idle_set = '{0, 46, 0, 10};
    stall_set = '{0, 0, 46, 10};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, hue wrap, greys, the linear segment, far out of gamut.
    send_colour(15'd0, 16'd0, 16'd0);
    send_colour(15'd0, 16'd0, 16'hFFFF);
    send_colour(15'd23039, 16'hFFFF, 16'hFFFF);
    send_colour(15'd23040, 16'd3000, 16'h9000);
    send_colour(15'd32767, 16'hFFFF, 16'd0);
    send_colour(15'h7FFF, 16'h1000, 16'h8000);
    send_colour(15'd5760, 16'd6000, 16'h8000);
    send_colour(15'd11520, 16'd6000, 16'h8000);
    send_colour(15'd17280, 16'd6000, 16'h8000);
    send_colour(15'd0, 16'd0, 16'd4000);
    send_colour(15'd0, 16'd0, 16'd9500);
    send_colour(15'd0, 16'd0, 16'd9600);
    send_colour(15'd1800, 16'd400, 16'd1500);
    send_colour(15'd0, 16'd0, 16'h8000);
    send_colour(15'd22, 16'h2000, 16'hC000);
    send_colour(15'd23017, 16'h2000, 16'h4000);
    send_colour(15'd2000, 16'hFFFF, 16'h8000);
    send_colour(15'd14000, 16'hFFFF, 16'hFFFF);
    send_colour(15'h5555, 16'h5555, 16'hAAAA);
    send_colour(15'h2AAA, 16'hAAAA, 16'h5555);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 225; n++) send_random();
      // Let the pipeline drain completely before the next phase.
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      wait (pending == 0);
    end

    s_axis_tvalid_i <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
